[sv/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Plain invariant checked every clock outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`endif

[sv/csfp_pkg.sv]
// Package: types, constants and helpers of the cron field parser
package csfp_pkg;
   localparam logic [6:0] NONE_MARK = 7'd127;

   typedef enum logic [2:0] {
      PH_GAP, PH_ATOM, PH_NUM, PH_NAME1, PH_NAME2, PH_AFTER, PH_STEP, PH_DEAD
   } phase_type;

   typedef enum logic [1:0] {ST_IDLE, ST_FILL, ST_OUT} state_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [59:0] minute_mask;
      logic [23:0] hour_mask;
      logic [31:0] day_mask;
      logic [11:0] month_mask;
      logic [6:0]  weekday_mask;
      logic        line_ok;
      logic [4:0]  field_errors;
   } rsp_type;

   // Size of field f
   function automatic logic [6:0] field_size(input logic [2:0] f);
      case (f)
         3'd0: field_size = 7'd60;
         3'd1: field_size = 7'd24;
         3'd2: field_size = 7'd32;
         3'd3: field_size = 7'd12;
         default: field_size = 7'd7;
      endcase
   endfunction

   function automatic logic [7:0] lower(input logic [7:0] c);
      lower = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
   endfunction

   // Name lookup: returns index or NONE_MARK
   function automatic logic [6:0] name_lookup(input logic month, input logic [23:0] n);
      logic [23:0] mon [12];
      logic [23:0] wdy [7];
      logic [6:0]  r;
      mon = '{"jan","feb","mar","apr","may","jun","jul","aug","sep","oct","nov","dec"};
      wdy = '{"sun","mon","tue","wed","thu","fri","sat"};
      r = NONE_MARK;
      if (month) begin
         for (int i = 11; i >= 0; i--)
            if (n == mon[i]) r = 7'(i);
      end else begin
         for (int i = 6; i >= 0; i--)
            if (n == wdy[i]) r = 7'(i);
      end
      name_lookup = r;
   endfunction
endpackage

[sv/csfp_stream_if.sv]
// Valid/ready stream interface
interface csfp_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[sv/cron_schedule_field_parser_core.sv]
// Top level: cron line parser with a sequential mask fill unit
// One character is taken per cycle while input ready is high. A character
// that closes a list item starts the fill unit, which walks one mask
// position per cycle, one per value of the item's range, so at most the
// field size (60 positions for minutes). Input ready is low meanwhile. The
// last character of a line then moves the parser to a state that loads the
// result into the output register. That load waits while an earlier result
// is still held there, and input ready stays low until it is done.
module cron_schedule_field_parser_core (
   input logic clock,
   input logic reset,
   input logic csr_we,
   input logic [7:0] csr_wdata,
   csfp_stream_if.sink req,
   csfp_stream_if.source rsp
);
   import csfp_pkg::*;

   logic [7:0]  delim_ff;
   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [2:0]  fnum_ff, fnum_in;
   logic [6:0]  lo_ff, lo_in, hi_ff, hi_in, acc_ff, acc_in, step_ff, step_in;
   logic [15:0] name_ff, name_in;
   logic [6:0]  pos_ff, pos_in, cnt_ff, cnt_in;
   logic [2:0]  ff_ff, ff_in;     // field being filled
   logic        fin_ff, fin_in;   // emit result after fill
   logic [59:0] m0_ff, m0_in;
   logic [23:0] m1_ff, m1_in;
   logic [31:0] m2_ff, m2_in;
   logic [11:0] m3_ff, m3_in;
   logic [6:0]  m4_ff, m4_in;
   logic [4:0]  err_ff, err_in;
   logic        ovld_ff, ovld_in;
   rsp_type     out_ff, out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= 8'd32;
         state_ff <= ST_IDLE;
         phase_ff <= PH_GAP;
         fnum_ff <= '0;
         ovld_ff <= 1'b0;
         fin_ff <= 1'b0;
         m0_ff <= '0; m1_ff <= '0; m2_ff <= '0; m3_ff <= '0; m4_ff <= '0;
         err_ff <= '0;
         lo_ff <= NONE_MARK; hi_ff <= NONE_MARK; acc_ff <= '0; step_ff <= 7'd1;
         name_ff <= '0;
      end else begin
         if (csr_we) delim_ff <= csr_wdata;
         state_ff <= state_in; phase_ff <= phase_in; fnum_ff <= fnum_in;
         ovld_ff <= ovld_in; fin_ff <= fin_in;
         m0_ff <= m0_in; m1_ff <= m1_in; m2_ff <= m2_in; m3_ff <= m3_in;
         m4_ff <= m4_in; err_ff <= err_in;
         lo_ff <= lo_in; hi_ff <= hi_in; acc_ff <= acc_in; step_ff <= step_in;
         name_ff <= name_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in; cnt_ff <= cnt_in; ff_ff <= ff_in; out_ff <= out_in;
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = ovld_ff;
   assign rsp.payload = out_ff;

   // Parser step, fill sequencer and output staging
   always_comb begin
      logic [7:0] c;
      logic       last, dl, dig, fl, close, cend, clr;
      logic [2:0] f;
      logic [6:0] md, off, v, fnd, nv;
      logic [10:0] wide;
      logic [31:0] dy;
      logic [6:0]  wd;
      logic        wu, du;
      state_in = state_ff; phase_in = phase_ff; fnum_in = fnum_ff;
      lo_in = lo_ff; hi_in = hi_ff; acc_in = acc_ff; step_in = step_ff;
      name_in = name_ff; pos_in = pos_ff; cnt_in = cnt_ff; ff_in = ff_ff;
      fin_in = fin_ff; m0_in = m0_ff; m1_in = m1_ff; m2_in = m2_ff;
      m3_in = m3_ff; m4_in = m4_ff; err_in = err_ff; out_in = out_ff;
      ovld_in = ovld_ff && !rsp.ready;
      c = req.payload.character; last = req.payload.last_char;
      dl = (delim_ff != 8'd0) && (c == delim_ff);
      fl = 1'b0; close = 1'b0; cend = 1'b0; clr = 1'b0;
      f = fnum_ff - 3'd1; dig = 1'b0; md = '0; off = '0; v = '0; fnd = '0;
      nv = '0; wide = '0; dy = '0; wd = '0; wu = 1'b0; du = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               // one parse pass per character; a second pass for line end
               for (int pass = 0; pass < 2; pass++) begin
                  logic e, run;
                  e = 1'b0; run = 1'b0;
                  if (pass == 0) begin
                     if (phase_in == PH_GAP) begin
                        if (!dl) begin
                           if (fnum_in < 3'd7) fnum_in = fnum_in + 3'd1;
                           lo_in = NONE_MARK; hi_in = NONE_MARK; acc_in = '0;
                           step_in = 7'd1; name_in = '0;
                           if (fnum_in <= 3'd5) begin
                              phase_in = PH_ATOM; run = 1'b1;
                           end else phase_in = PH_DEAD;
                        end
                     end else if (dl) begin
                        if (phase_in != PH_DEAD) begin
                           run = 1'b1; e = 1'b1;
                        end else phase_in = PH_GAP;
                     end else if (phase_in != PH_DEAD) run = 1'b1;
                  end else begin
                     // an item closed by a comma on the last character still
                     // sees the line end and flags the missing item
                     if (last && phase_in != PH_GAP && phase_in != PH_DEAD
                         && fnum_in >= 3'd1 && fnum_in <= 3'd5) begin
                        run = 1'b1; e = 1'b1;
                     end
                  end
                  if (run) begin
                     f = fnum_in - 3'd1; md = field_size(f);
                     dig = !e && c >= 8'h30 && c <= 8'h39;
                     off = (f == 3'd3) ? 7'd1 : 7'd0;
                     case (phase_in)
                        PH_ATOM: begin
                           if (e) begin err_in[f] = 1'b1; phase_in = PH_DEAD; end
                           else if (c == 8'h2a) begin
                              lo_in = '0; hi_in = md - 7'd1; phase_in = PH_AFTER;
                           end else if (dig) begin
                              acc_in = 7'(c - 8'h30); phase_in = PH_NUM;
                           end else if (f >= 3'd3) begin
                              name_in = {8'd0, c}; phase_in = PH_NAME1;
                           end else begin err_in[f] = 1'b1; phase_in = PH_DEAD; end
                        end
                        PH_NUM: begin
                           if (dig) begin
                              wide = 11'(acc_in) * 11'd10 + 11'(c - 8'h30);
                              acc_in = (wide > 11'd127) ? 7'd127 : wide[6:0];
                           end else if (acc_in < off || acc_in - off >= md) begin
                              err_in[f] = 1'b1; phase_in = PH_DEAD;
                           end else begin
                              v = acc_in - off;
                              if (lo_in == NONE_MARK) lo_in = v; else hi_in = v;
                              phase_in = PH_AFTER; close = 1'b1;
                           end
                        end
                        PH_NAME1: begin
                           if (e) begin err_in[f] = 1'b1; phase_in = PH_DEAD; end
                           else begin
                              name_in[15:8] = c; phase_in = PH_NAME2;
                           end
                        end
                        PH_NAME2: begin
                           fnd = name_lookup(f == 3'd3,
                              {lower(name_in[7:0]), lower(name_in[15:8]), lower(c)});
                           if (e || fnd == NONE_MARK) begin
                              err_in[f] = 1'b1; phase_in = PH_DEAD;
                           end else begin
                              if (lo_in == NONE_MARK) lo_in = fnd; else hi_in = fnd;
                              phase_in = PH_AFTER;
                           end
                        end
                        PH_AFTER: close = 1'b1;
                        PH_STEP: begin
                           if (dig) begin
                              wide = 11'(step_in) * 11'd10 + 11'(c - 8'h30);
                              step_in = (wide > 11'd127) ? 7'd127 : wide[6:0];
                           end else begin
                              fl = 1'b1; cend = 1'b1;
                           end
                        end
                        default: ;
                     endcase
                     // after-atom handling
                     if (close) begin
                        close = 1'b0;
                        if (!e && c == 8'h2d && hi_in == NONE_MARK) phase_in = PH_ATOM;
                        else begin
                           if (hi_in == NONE_MARK) hi_in = lo_in;
                           if (!e && c == 8'h2f) begin
                              step_in = '0; phase_in = PH_STEP;
                           end else begin
                              fl = 1'b1; cend = 1'b1;
                           end
                        end
                     end
                     // item close: fill then settle phase
                     if (cend) begin
                        cend = 1'b0; ff_in = f;
                        if (e) phase_in = PH_GAP;
                        else if (c == 8'h2c) phase_in = PH_ATOM;
                        else begin err_in[f] = 1'b1; phase_in = PH_DEAD; end
                     end
                  end
                  if (pass == 0 && dl) begin
                     if (phase_in != PH_DEAD || run) phase_in = PH_GAP;
                  end
               end
               fin_in = last;
               if (fl) begin
                  pos_in = lo_in; cnt_in = 7'd1; state_in = ST_FILL;
               end else if (last) state_in = ST_OUT;
            end
         end
         ST_FILL: begin
            // one mask position per cycle
            md = field_size(ff_ff);
            nv = cnt_ff - 7'd1;
            if (nv == 7'd0) begin
               case (ff_ff)
                  3'd0: m0_in[pos_ff[5:0]] = 1'b1;
                  3'd1: m1_in[pos_ff[4:0]] = 1'b1;
                  3'd2: m2_in[pos_ff[4:0]] = 1'b1;
                  3'd3: m3_in[pos_ff[3:0]] = 1'b1;
                  default: m4_in[pos_ff[2:0]] = 1'b1;
               endcase
               nv = step_ff;
            end
            cnt_in = nv;
            if (pos_ff == hi_ff || pos_ff >= md) begin
               // list item done: reset item state if comma continues
               if (phase_ff == PH_ATOM) begin
                  lo_in = NONE_MARK; hi_in = NONE_MARK; step_in = 7'd1;
               end
               state_in = fin_ff ? ST_OUT : ST_IDLE;
            end else pos_in = (pos_ff + 7'd1 == md) ? 7'd0 : pos_ff + 7'd1;
         end
         ST_OUT: begin
            if (!ovld_ff || rsp.ready) begin
               dy = m2_ff; wd = m4_ff;
               wu = wd != 7'h7f; du = dy != 32'hffffffff;
               if (wu && !du) dy = '0;
               if (du && !wu) wd = '0;
               if (fnum_ff >= 3'd5)
                  out_in = '{m0_ff, m1_ff, dy, m3_ff, wd, 1'b1, err_ff};
               else out_in = '0;
               ovld_in = 1'b1; clr = 1'b1; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (clr) begin
         fnum_in = '0; phase_in = PH_GAP; lo_in = NONE_MARK; hi_in = NONE_MARK;
         acc_in = '0; step_in = 7'd1; name_in = '0; fin_in = 1'b0;
         m0_in = '0; m1_in = '0; m2_in = '0; m3_in = '0; m4_in = '0; err_in = '0;
      end
   end
endmodule

[sv/csfp_checker.sv]
// Port-level checker for the cron field parser, bound to the top level
`include "assert_macros.svh"
module csfp_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_line_ok,
   input logic [4:0] rsp_field_errors,
   input logic [59:0] rsp_minute_mask
);
   `ASSERT_IMPL(a_short_zero, clock, reset, (rsp_valid && !rsp_line_ok) |-> (rsp_field_errors == 5'd0 && rsp_minute_mask == 60'd0), "short line result not zero")
   `ASSERT_IMPL(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "result dropped")
   `ASSERT_IMPL(a_rsp_stable, clock, reset, (rsp_valid && !rsp_ready) |=> $stable(rsp_minute_mask), "result changed")
endmodule

bind cron_schedule_field_parser_core csfp_checker u_csfp_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_line_ok(rsp.payload.line_ok), .rsp_field_errors(rsp.payload.field_errors),
   .rsp_minute_mask(rsp.payload.minute_mask)
);
